// ===== design/crl_pkg.sv =====
// ----------------------------------------------------------------------------
// crl_pkg
// shared types, field widths and command, status, mode and register codes
// ----------------------------------------------------------------------------
package crl_pkg;

  localparam int SECRET_CHARS_DEF = 16;

  localparam int CMD_W     = 3;
  localparam int TIME_W    = 32;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int MODE_W    = 2;
  localparam int NPICK     = 4;
  localparam int NREPLY    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_ISSUE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUBMIT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POLL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_IDLE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NOTE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BYPASS = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESET  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPICK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOACT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SUCCESS = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_LOCKED  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AWAIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_HI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECRET_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAL_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SESS_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TIME = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRY_LIMIT    = 3'd6;

  localparam logic [TIME_W-1:0] CHAL_TIMEOUT_RST = 32'd60000;
  localparam logic [TIME_W-1:0] SESS_TIMEOUT_RST = 32'd600000;
  localparam logic [TIME_W-1:0] LOCKOUT_TIME_RST = 32'd300000;
  localparam logic [CNT_W-1:0]  TRY_LIMIT_RST    = 8'd3;

  typedef struct packed {
    logic [CMD_W-1:0]                command;
    logic [TIME_W-1:0]               now_ms;
    logic [NPICK-1:0][POS_W-1:0]     pick;
    logic [NREPLY-1:0][BYTE_W-1:0]   reply;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MODE_W-1:0]   mode_now;
    logic [CNT_W-1:0]    failures;
    logic [TIME_W-1:0]   challenge_number;
    logic                event_flag;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]  secret_length;
    logic [TIME_W-1:0] challenge_timeout;
    logic [TIME_W-1:0] session_timeout;
    logic [TIME_W-1:0] lockout_time;
    logic [CNT_W-1:0]  try_limit;
  } cfg_t;

endpackage

// ===== design/crl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crl_cfg_regs
// configuration registers: secret characters, length, timeouts and limit
// ----------------------------------------------------------------------------
module crl_cfg_regs #(
  parameter int SECRET_CHARS = crl_pkg::SECRET_CHARS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [crl_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [crl_pkg::CFG_W-1:0]              cfg_data_i,
  output crl_pkg::cfg_t                          cfg_o,
  output logic [SECRET_CHARS-1:0][crl_pkg::BYTE_W-1:0] secret_o
);
  import crl_pkg::*;

  logic [SECRET_CHARS-1:0][BYTE_W-1:0] secret_q;
  cfg_t                                cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secret_q                <= '0;
      cfg_q.secret_length     <= '0;
      cfg_q.challenge_timeout <= CHAL_TIMEOUT_RST;
      cfg_q.session_timeout   <= SESS_TIMEOUT_RST;
      cfg_q.lockout_time      <= LOCKOUT_TIME_RST;
      cfg_q.try_limit         <= TRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      for (int b = 0; b < SECRET_CHARS; b++) begin
        if ((b < 8 && cfg_idx_i == REG_SECRET_LO) ||
            (b >= 8 && cfg_idx_i == REG_SECRET_HI)) begin
          secret_q[b] <= cfg_data_i[BYTE_W*(b%8) +: BYTE_W];
        end
      end
      unique case (cfg_idx_i)
        REG_SECRET_LEN:   cfg_q.secret_length     <= cfg_data_i[LEN_W-1:0];
        REG_CHAL_TIMEOUT: cfg_q.challenge_timeout <= cfg_data_i[TIME_W-1:0];
        REG_SESS_TIMEOUT: cfg_q.session_timeout   <= cfg_data_i[TIME_W-1:0];
        REG_LOCKOUT_TIME: cfg_q.lockout_time      <= cfg_data_i[TIME_W-1:0];
        REG_TRY_LIMIT:    cfg_q.try_limit         <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o    = cfg_q;
  assign secret_o = secret_q;

endmodule

// ===== design/crl_resp_check.sv =====
// ----------------------------------------------------------------------------
// crl_resp_check
// greedy match of four wanted characters against six reply bytes, each used at most once; a zero reply byte fails
// ----------------------------------------------------------------------------
module crl_resp_check (
  input  logic [crl_pkg::NPICK-1:0][crl_pkg::BYTE_W-1:0]  want_i,
  input  logic [crl_pkg::NREPLY-1:0][crl_pkg::BYTE_W-1:0] reply_i,
  output logic                                            pass_o
);
  import crl_pkg::*;

  always_comb begin
    logic [NREPLY-1:0] taken;
    logic              hit;
    taken  = '0;
    pass_o = 1'b1;
    for (int j = 0; j < NREPLY; j++) begin
      if (reply_i[j] == '0) pass_o = 1'b0;
    end
    for (int i = 0; i < NPICK; i++) begin
      hit = 1'b0;
      for (int j = 0; j < NREPLY; j++) begin
        if (!hit && !taken[j] && reply_i[j] == want_i[i]) begin
          taken[j] = 1'b1;
          hit      = 1'b1;
        end
      end
      if (!hit) pass_o = 1'b0;
    end
  end

endmodule

// ===== design/crl_core.sv =====
// ----------------------------------------------------------------------------
// crl_core
// session state registers and the per-command update and result logic
// ----------------------------------------------------------------------------
module crl_core #(
  parameter int SECRET_CHARS = crl_pkg::SECRET_CHARS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         fire_i,
  input  crl_pkg::cmd_item_t                           item_i,
  input  crl_pkg::cfg_t                                cfg_i,
  input  logic [SECRET_CHARS-1:0][crl_pkg::BYTE_W-1:0] secret_i,
  output crl_pkg::result_t                             res_o
);
  import crl_pkg::*;

  localparam int IDX_W = $clog2(SECRET_CHARS);

  logic [MODE_W-1:0]            mode_q, mode_d;
  logic [CNT_W-1:0]             failed_q, failed_d;
  logic [TIME_W-1:0]            next_chal_q, next_chal_d;
  logic [TIME_W-1:0]            deadline_q, deadline_d;
  logic [TIME_W-1:0]            lock_end_q, lock_end_d;
  logic [TIME_W-1:0]            last_act_q, last_act_d;
  logic [NPICK-1:0][IDX_W-1:0]  pos_q, pos_d;

  logic [LEN_W-1:0]             len;
  logic                         picks_bad;
  logic [NPICK-1:0][IDX_W-1:0]  pick_idx;
  logic [NPICK-1:0][BYTE_W-1:0] want;
  logic                         pass;
  logic [TIME_W-1:0]            chal_inc;
  logic [CNT_W-1:0]             failed_inc;

  assign len = (cfg_i.secret_length > LEN_W'(SECRET_CHARS)) ?
               LEN_W'(SECRET_CHARS) : cfg_i.secret_length;

  always_comb begin
    logic [POS_W-1:0] pm1;
    picks_bad = 1'b0;
    pick_idx  = '0;
    for (int i = 0; i < NPICK; i++) begin
      pm1         = item_i.pick[i] - POS_W'(1);
      pick_idx[i] = pm1[IDX_W-1:0];
      if (item_i.pick[i] == '0 || item_i.pick[i] > len) picks_bad = 1'b1;
      for (int j = 0; j < NPICK; j++) begin
        if (j < i && item_i.pick[j] == item_i.pick[i]) picks_bad = 1'b1;
      end
    end
    for (int i = 0; i < NPICK; i++) begin
      want[i] = secret_i[pos_q[i]];
    end
  end

  crl_resp_check u_check (
    .want_i  (want),
    .reply_i (item_i.reply),
    .pass_o  (pass)
  );

  assign chal_inc   = next_chal_q + TIME_W'(1);
  assign failed_inc = (failed_q != '1) ? failed_q + CNT_W'(1) : failed_q;

  always_comb begin
    mode_d      = mode_q;
    failed_d    = failed_q;
    next_chal_d = next_chal_q;
    deadline_d  = deadline_q;
    lock_end_d  = lock_end_q;
    last_act_d  = last_act_q;
    pos_d       = pos_q;
    res_o.status           = ST_OK;
    res_o.challenge_number = '0;
    res_o.event_flag       = 1'b0;
    unique case (item_i.command)
      CMD_ISSUE: begin
        if (len < LEN_W'(NPICK)) begin
          res_o.status = ST_SHORT;
        end else if (picks_bad) begin
          res_o.status = ST_BADPICK;
        end else begin
          pos_d       = pick_idx;
          next_chal_d = (chal_inc == '0) ? TIME_W'(1) : chal_inc;
          deadline_d  = item_i.now_ms + cfg_i.challenge_timeout;
          mode_d      = MODE_AWAIT;
          res_o.challenge_number = next_chal_d;
        end
      end
      CMD_SUBMIT: begin
        if (mode_q != MODE_AWAIT) begin
          res_o.status = ST_NOACT;
        end else begin
          deadline_d = '0;
          pos_d      = '0;
          mode_d     = MODE_IDLE;
          if (item_i.now_ms > deadline_q) begin
            res_o.status = ST_EXPIRED;
          end else if (pass) begin
            failed_d     = '0;
            mode_d       = MODE_AUTH;
            last_act_d   = item_i.now_ms;
            res_o.status = ST_SUCCESS;
          end else begin
            failed_d = failed_inc;
            if (failed_inc >= cfg_i.try_limit) begin
              mode_d       = MODE_LOCKED;
              lock_end_d   = item_i.now_ms + cfg_i.lockout_time;
              res_o.status = ST_LOCKED;
            end else begin
              res_o.status = ST_FAILED;
            end
          end
        end
      end
      CMD_POLL: begin
        if (mode_q == MODE_LOCKED) begin
          if (item_i.now_ms >= lock_end_q) begin
            mode_d     = MODE_IDLE;
            failed_d   = '0;
            lock_end_d = '0;
          end else begin
            res_o.event_flag = 1'b1;
          end
        end
      end
      CMD_IDLE: begin
        if (mode_q == MODE_AUTH &&
            (item_i.now_ms - last_act_q) > cfg_i.session_timeout) begin
          mode_d           = MODE_IDLE;
          last_act_d       = '0;
          res_o.event_flag = 1'b1;
        end
      end
      CMD_NOTE: begin
        if (mode_q == MODE_AUTH) last_act_d = item_i.now_ms;
      end
      CMD_BYPASS: begin
        failed_d   = '0;
        mode_d     = MODE_AUTH;
        last_act_d = item_i.now_ms;
      end
      CMD_RESET: begin
        mode_d     = MODE_IDLE;
        failed_d   = '0;
        lock_end_d = '0;
        last_act_d = '0;
        deadline_d = '0;
        pos_d      = '0;
      end
      default: ;
    endcase
    res_o.mode_now = mode_d;
    res_o.failures = failed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      failed_q    <= '0;
      next_chal_q <= '0;
      deadline_q  <= '0;
      lock_end_q  <= '0;
      last_act_q  <= '0;
      pos_q       <= '0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      failed_q    <= failed_d;
      next_chal_q <= next_chal_d;
      deadline_q  <= deadline_d;
      lock_end_q  <= lock_end_d;
      last_act_q  <= last_act_d;
      pos_q       <= pos_d;
    end
  end

endmodule

// ===== design/challenge_response_auth_lockout.sv =====
// ----------------------------------------------------------------------------
// challenge_response_auth_lockout
// challenge-response authentication with failure lockout and session timeout
// ----------------------------------------------------------------------------
// One command is taken per clock while the result side does not stall, and
// each gives exactly one result beat. A command is captured in an input
// register, evaluated combinationally against the session state and written
// to a result register once that register is free or being taken. The state
// update of each command is registered with its result, so the next command
// sees it. The input side keeps accepting while a result waits to be taken,
// until both registers are full. The user must write configuration registers
// through the plain write port while no command is in flight; the block
// itself does not enforce this. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module challenge_response_auth_lockout #(
  parameter int SECRET_CHARS = crl_pkg::SECRET_CHARS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [crl_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms, pick0..pick3, reply_byte0..reply_byte5, zero pad
  input  logic [crl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // command
  input  logic [crl_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // mode_now, failures, challenge_number, event_flag, zero pad
  output logic [crl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [crl_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import crl_pkg::*;

  cfg_t                                cfg;
  logic [SECRET_CHARS-1:0][BYTE_W-1:0] secret;
  cmd_item_t                           in_q;
  logic                                in_valid_q;
  result_t                             res;
  result_t                             out_q;
  logic                                out_valid_q;
  logic                                fire;

  crl_cfg_regs #(.SECRET_CHARS(SECRET_CHARS)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .secret_o   (secret)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command <= s_axis_tuser;
      in_q.now_ms  <= s_axis_tdata[31:0];
      in_q.pick    <= s_axis_tdata[51:32];
      in_q.reply   <= s_axis_tdata[99:52];
    end
  end

  crl_core #(.SECRET_CHARS(SECRET_CHARS)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .secret_i (secret),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {5'd0, out_q.event_flag, out_q.challenge_number,
                          out_q.failures, out_q.mode_now};

endmodule

// ===== design/crl_checker.sv =====
// ----------------------------------------------------------------------------
// crl_checker
// port-level checks on result beats of the authentication block
// ----------------------------------------------------------------------------
module crl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [crl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [crl_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import crl_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // success leaves an authenticated session with no failures
  a_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_SUCCESS |->
      m_axis_tdata[1:0] == MODE_AUTH && m_axis_tdata[9:2] == '0)
    else $error("success without authenticated mode");

  // lockout status always reports locked mode
  a_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_LOCKED |->
      m_axis_tdata[1:0] == MODE_LOCKED && m_axis_tdata[9:2] != '0)
    else $error("lockout status with wrong mode");

  // a challenge id only comes with a good issue
  a_chal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[41:10] != '0 |->
      m_axis_tuser == ST_OK && m_axis_tdata[1:0] == MODE_AWAIT && !m_axis_tdata[42])
    else $error("challenge id on a beat that issued none");

endmodule

bind challenge_response_auth_lockout crl_checker u_crl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/challenge_response_auth_lockout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// challenge_response_auth_lockout_tb
// self-checking bench: commands go in on the slave stream, every result beat
// is compared field by field with a cycle-free model of the session logic,
// under random stalls on both sides and several register settings
// ----------------------------------------------------------------------------
module challenge_response_auth_lockout_tb;
  import crl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam int ANS_GOOD    = 0;
  localparam int ANS_WRONG   = 1;
  localparam int ANS_ZERO    = 2;
  localparam int WDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // now_ms, pick0..pick3, reply_byte0..reply_byte5, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // command
  logic [CMD_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // mode_now, failures, challenge_number, event_flag, zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [STATUS_W-1:0]  m_axis_tuser;

  challenge_response_auth_lockout u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  int      err_cnt      = 0;
  int      src_idle_pct = 17;
  int      snk_idle_pct = 71;
  bit      hold_req     = 1'b0;
  int      hold_left    = 0;
  int      idle_cycles  = 0;
  result_t expected_q[$];
  logic [31:0] clock_ms = '0;

  // register copies
  logic [63:0] cfg_secret_lo  = '0;
  logic [63:0] cfg_secret_hi  = '0;
  logic [4:0]  cfg_len        = '0;
  logic [31:0] cfg_chal_to    = CHAL_TIMEOUT_RST;
  logic [31:0] cfg_sess_to    = SESS_TIMEOUT_RST;
  logic [31:0] cfg_lock_time  = LOCKOUT_TIME_RST;
  logic [7:0]  cfg_max_tries  = TRY_LIMIT_RST;

  // session state
  logic [MODE_W-1:0] st_mode       = MODE_IDLE;
  logic [7:0]        fail_cnt      = '0;
  logic [31:0]       chal_ctr      = '0;
  logic [31:0]       chal_active   = '0;
  logic [31:0]       chal_deadline = '0;
  logic [31:0]       lock_until    = '0;
  logic [31:0]       last_seen     = '0;
  logic [4:0]        chal_pos [NPICK] = '{default: '0};

  function automatic logic [4:0] eff_len();
    return (cfg_len > SECRET_CHARS_DEF) ? 5'(SECRET_CHARS_DEF) : cfg_len;
  endfunction

  function automatic logic [7:0] secret_at(input logic [4:0] pos);
    logic [3:0] k;
    k = 4'(pos - 5'd1);
    return k[3] ? cfg_secret_hi[k[2:0]*8 +: 8] : cfg_secret_lo[k[2:0]*8 +: 8];
  endfunction

  function automatic void drop_challenge();
    chal_active   = '0;
    chal_deadline = '0;
    for (int i = 0; i < NPICK; i++) chal_pos[i] = '0;
    if (st_mode == MODE_AWAIT) st_mode = MODE_IDLE;
  endfunction

  // greedy match of challenged characters against unused reply bytes
  function automatic logic reply_matches(input cmd_item_t it);
    logic [NREPLY-1:0] taken;
    logic              hit;
    logic [7:0]        want;
    taken = '0;
    if (chal_active == 0) return 1'b0;
    for (int j = 0; j < NREPLY; j++)
      if (it.reply[j] == 8'h00) return 1'b0;
    for (int i = 0; i < NPICK; i++) begin
      if (chal_pos[i] == 0 || chal_pos[i] > 5'd16) return 1'b0;
      want = secret_at(chal_pos[i]);
      hit  = 1'b0;
      for (int j = 0; j < NREPLY; j++) begin
        if (!hit && !taken[j] && it.reply[j] == want) begin
          taken[j] = 1'b1;
          hit      = 1'b1;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_step(input cmd_item_t it);
    result_t     r;
    logic [4:0]  len;
    logic        good;
    logic [31:0] gap;
    r = '0;
    r.status = ST_OK;
    case (it.command)
      CMD_ISSUE: begin
        len  = eff_len();
        good = 1'b1;
        for (int i = 0; i < NPICK; i++) begin
          if (it.pick[i] == 0 || it.pick[i] > len) good = 1'b0;
          for (int j = 0; j < i; j++)
            if (it.pick[j] == it.pick[i]) good = 1'b0;
        end
        if (len < NPICK) begin
          r.status = ST_SHORT;
        end else if (!good) begin
          r.status = ST_BADPICK;
        end else begin
          for (int i = 0; i < NPICK; i++) chal_pos[i] = it.pick[i];
          chal_ctr = chal_ctr + 32'd1;
          if (chal_ctr == 0) chal_ctr = 32'd1;
          chal_active        = chal_ctr;
          chal_deadline      = it.now_ms + cfg_chal_to;
          st_mode            = MODE_AWAIT;
          r.challenge_number = chal_active;
        end
      end
      CMD_SUBMIT: begin
        if (chal_active == 0 || st_mode != MODE_AWAIT) begin
          r.status = ST_NOACT;
        end else if (it.now_ms > chal_deadline) begin
          drop_challenge();
          r.status = ST_EXPIRED;
        end else begin
          good = reply_matches(it);
          drop_challenge();
          if (good) begin
            fail_cnt  = '0;
            st_mode   = MODE_AUTH;
            last_seen = it.now_ms;
            r.status  = ST_SUCCESS;
          end else begin
            if (fail_cnt != 8'hFF) fail_cnt = fail_cnt + 8'd1;
            if (fail_cnt >= cfg_max_tries) begin
              st_mode    = MODE_LOCKED;
              lock_until = it.now_ms + cfg_lock_time;
              r.status   = ST_LOCKED;
            end else begin
              st_mode  = MODE_IDLE;
              r.status = ST_FAILED;
            end
          end
        end
      end
      CMD_POLL: begin
        if (st_mode == MODE_LOCKED) begin
          if (it.now_ms >= lock_until) begin
            st_mode    = MODE_IDLE;
            fail_cnt   = '0;
            lock_until = '0;
          end else begin
            r.event_flag = 1'b1;
          end
        end
      end
      CMD_IDLE: begin
        gap = it.now_ms - last_seen;
        if (st_mode == MODE_AUTH && gap > cfg_sess_to) begin
          st_mode      = MODE_IDLE;
          last_seen    = '0;
          r.event_flag = 1'b1;
        end
      end
      CMD_NOTE: begin
        if (st_mode == MODE_AUTH) last_seen = it.now_ms;
      end
      CMD_BYPASS: begin
        fail_cnt  = '0;
        st_mode   = MODE_AUTH;
        last_seen = it.now_ms;
      end
      CMD_RESET: begin
        st_mode    = MODE_IDLE;
        fail_cnt   = '0;
        lock_until = '0;
        last_seen  = '0;
        drop_challenge();
      end
      default: begin
      end
    endcase
    r.mode_now = st_mode;
    r.failures = fail_cnt;
    return r;
  endfunction

  function automatic cmd_item_t noise_item(input logic [CMD_W-1:0] cmd, input logic [31:0] now);
    cmd_item_t it;
    it.command = cmd;
    it.now_ms  = now;
    for (int i = 0; i < NPICK; i++) it.pick[i] = 5'($urandom_range(31));
    for (int j = 0; j < NREPLY; j++) it.reply[j] = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic cmd_item_t issue_with(input logic [31:0] now, input logic [4:0] a,
                                           input logic [4:0] b, input logic [4:0] c,
                                           input logic [4:0] d);
    cmd_item_t it;
    it = noise_item(CMD_ISSUE, now);
    it.pick[0] = a;
    it.pick[1] = b;
    it.pick[2] = c;
    it.pick[3] = d;
    return it;
  endfunction

  function automatic cmd_item_t issue_item(input logic [31:0] now);
    cmd_item_t  it;
    logic [4:0] len;
    logic       dup;
    it  = noise_item(CMD_ISSUE, now);
    len = eff_len();
    if (len >= NPICK) begin
      for (int i = 0; i < NPICK; i++) begin
        do begin
          it.pick[i] = 5'($urandom_range(1, len));
          dup = 1'b0;
          for (int j = 0; j < i; j++)
            if (it.pick[j] == it.pick[i]) dup = 1'b1;
        end while (dup);
      end
    end
    return it;
  endfunction

  // reply built from the characters currently challenged, shuffled
  function automatic cmd_item_t answer_item(input logic [31:0] now, input int kind);
    cmd_item_t  it;
    logic [7:0] tmp;
    int         k;
    it = noise_item(CMD_SUBMIT, now);
    for (int i = 0; i < NPICK; i++) it.reply[i] = secret_at(chal_pos[i]);
    if ($urandom_range(1)) it.reply[4] = secret_at(5'($urandom_range(1, 16)));
    for (int j = NREPLY - 1; j > 0; j--) begin
      k           = $urandom_range(j);
      tmp         = it.reply[j];
      it.reply[j] = it.reply[k];
      it.reply[k] = tmp;
    end
    k = $urandom_range(NREPLY - 1);
    if (kind == ANS_WRONG) it.reply[k] = it.reply[k] ^ 8'($urandom_range(1, 255));
    else if (kind == ANS_ZERO) it.reply[k] = 8'h00;
    return it;
  endfunction

  task automatic send_item(input cmd_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.reply, it.pick, it.now_ms};
    s_axis_tuser  <= it.command;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_step(it));
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len,
                           input logic [31:0] cto, input logic [31:0] sto,
                           input logic [31:0] lt, input logic [7:0] ma);
    settle();
    cfg_we_i <= 1'b1;
    put_reg(REG_SECRET_LO, lo);
    put_reg(REG_SECRET_HI, hi);
    put_reg(REG_SECRET_LEN, {59'd0, len});
    put_reg(REG_CHAL_TIMEOUT, {32'd0, cto});
    put_reg(REG_SESS_TIMEOUT, {32'd0, sto});
    put_reg(REG_LOCKOUT_TIME, {32'd0, lt});
    put_reg(REG_TRY_LIMIT, {56'd0, ma});
    cfg_we_i      <= 1'b0;
    cfg_secret_lo = lo;
    cfg_secret_hi = hi;
    cfg_len       = len;
    cfg_chal_to   = cto;
    cfg_sess_to   = sto;
    cfg_lock_time = lt;
    cfg_max_tries = ma;
  endtask

  // mostly issue/answer pairs, plus session commands aimed at their boundaries
  task automatic run_random(input int n);
    int          sent;
    int          pick;
    logic [31:0] now;
    sent = 0;
    while (sent < n) begin
      pick     = $urandom_range(99);
      clock_ms = clock_ms + 32'($urandom_range(0, 3000));
      now      = clock_ms;
      if (pick < 42) begin
        send_item(issue_item(now));
        pick = $urandom_range(99);
        if (pick < 12) now = chal_deadline + 32'($urandom_range(0, 3));
        else now = clock_ms + 32'($urandom_range(0, 50));
        clock_ms = now;
        send_item(answer_item(now, (pick < 55) ? ANS_GOOD : (pick < 90) ? ANS_WRONG : ANS_ZERO));
        sent += 2;
      end else begin
        if (pick < 52) begin
          if (st_mode == MODE_LOCKED && $urandom_range(1))
            now = lock_until - 32'd1 + 32'($urandom_range(0, 2));
          send_item(noise_item(CMD_POLL, now));
        end else if (pick < 62) begin
          if (st_mode == MODE_AUTH && $urandom_range(1))
            now = last_seen + cfg_sess_to + 32'($urandom_range(0, 2));
          send_item(noise_item(CMD_IDLE, now));
        end else if (pick < 68) begin
          send_item(noise_item(CMD_NOTE, now));
        end else if (pick < 73) begin
          send_item(noise_item(CMD_BYPASS, now));
        end else if (pick < 76) begin
          send_item(noise_item(CMD_RESET, now));
        end else if (pick < 78) begin
          send_item(noise_item(CMD_SPARE, now));
        end else if (pick < 86) begin
          send_item(answer_item(now, ANS_GOOD));
        end else begin
          send_item(noise_item(3'($urandom_range(7)), $urandom));
        end
        sent++;
      end
    end
  endtask

  task automatic test_unconfigured();
    send_item(issue_with(32'd0, 5'd1, 5'd2, 5'd3, 5'd4));
    send_item(answer_item(32'd1, ANS_GOOD));
    send_item(noise_item(CMD_POLL, 32'd2));
    send_item(noise_item(CMD_NOTE, 32'd3));
    send_item(noise_item(CMD_BYPASS, 32'd4));
    send_item(noise_item(CMD_IDLE, 32'hFFFF_FFFF));
    send_item(noise_item(CMD_RESET, 32'd5));
    send_item(noise_item(CMD_SPARE, 32'd6));
  endtask

  task automatic test_directed_cases();
    configure(64'h807F_01FF_4433_2211, 64'hF0E1_D2C3_B4A5_9600, 5'd16,
              32'd100, 32'd1000, 32'd500, 8'd2);
    send_item(issue_with(32'd1000, 5'd1, 5'd16, 5'd8, 5'd2));
    send_item(answer_item(32'd1100, ANS_GOOD));
    send_item(noise_item(CMD_IDLE, 32'd2100));
    send_item(noise_item(CMD_NOTE, 32'd2200));
    send_item(noise_item(CMD_IDLE, 32'd3201));
    send_item(issue_with(32'd3300, 5'd0, 5'd1, 5'd2, 5'd3));
    send_item(issue_with(32'd3300, 5'd1, 5'd2, 5'd3, 5'd17));
    send_item(issue_with(32'd3300, 5'd5, 5'd6, 5'd5, 5'd7));
    send_item(issue_with(32'd3300, 5'd31, 5'd1, 5'd2, 5'd3));
    send_item(issue_with(32'd4000, 5'd3, 5'd4, 5'd5, 5'd6));
    send_item(answer_item(32'd4010, ANS_ZERO));
    // position 9 holds a zero character, so even the right answer fails
    send_item(issue_with(32'd5000, 5'd9, 5'd10, 5'd11, 5'd12));
    send_item(answer_item(32'd5010, ANS_GOOD));
    send_item(noise_item(CMD_POLL, 32'd5509));
    send_item(noise_item(CMD_POLL, 32'd5510));
    send_item(issue_with(32'd6000, 5'd13, 5'd14, 5'd15, 5'd16));
    send_item(answer_item(32'd6101, ANS_GOOD));
    send_item(answer_item(32'd6102, ANS_GOOD));
    // deadline wraps past zero
    send_item(issue_with(32'hFFFF_FFF0, 5'd4, 5'd3, 5'd2, 5'd1));
    send_item(answer_item(32'hFFFF_FFF1, ANS_GOOD));
    send_item(noise_item(CMD_BYPASS, 32'd7000));
    send_item(noise_item(CMD_RESET, 32'd7001));
    clock_ms = 32'd8000;
  endtask

  task automatic test_random_nominal();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd16,
              32'd60000, 32'd5000, 32'd2000, 8'd3);
    run_random(250);
  endtask

  task automatic test_random_tight();
    src_idle_pct = 71;
    snk_idle_pct = 17;
    configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd4, 32'd1, 32'd1, 32'd1, 8'd1);
    run_random(150);
  endtask

  task automatic test_random_wide();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 5'd31,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    run_random(150);
  endtask

  task automatic test_random_zero_limits();
    configure({$urandom, $urandom}, 64'd0, 5'd3, 32'd0, 32'd0, 32'd0, 8'd0);
    run_random(50);
    configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 32'd0, 32'd0, 32'd0, 8'd0);
    run_random(50);
  endtask

  task automatic test_random_mid();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(5, 15)),
              32'($urandom_range(100, 10000)), 32'($urandom_range(100, 10000)),
              32'($urandom_range(100, 10000)), 8'd2);
    run_random(150);
  endtask

  task automatic test_backpressure();
    configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd16,
              32'd5000, 32'd5000, 32'd3000, 8'd3);
    hold_req = 1'b1;
    run_random(30);
    settle();
    run_random(10);
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      {got.event_flag, got.challenge_number, got.failures, got.mode_now} = m_axis_tdata[42:0];
      if (expected_q.size() == 0) begin
        $error("result beat with no command pending");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
          err_cnt++;
        end
        if (got.failures !== want.failures) begin
          $error("failures: expected %0d, got %0d", want.failures, got.failures);
          err_cnt++;
        end
        if (got.challenge_number !== want.challenge_number) begin
          $error("challenge_number: expected %0d, got %0d",
                 want.challenge_number, got.challenge_number);
          err_cnt++;
        end
        if (got.event_flag !== want.event_flag) begin
          $error("event_flag: expected %0d, got %0d", want.event_flag, got.event_flag);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unconfigured();
    test_directed_cases();
    test_random_nominal();
    test_random_tight();
    test_random_wide();
    test_random_zero_limits();
    test_random_mid();
    test_backpressure();
    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== challenge_response_auth_lockout.f =====
design/crl_pkg.sv
design/crl_cfg_regs.sv
design/crl_resp_check.sv
design/crl_core.sv
design/challenge_response_auth_lockout.sv
design/crl_checker.sv
tb/challenge_response_auth_lockout_tb.sv
